// ===== hw/rtl/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// Convex hull scan package
// Shared constants, codes and types of the convex hull scan block.
// ----------------------------------------------------------------------------
package chs_pkg;

   // Default sizes of the point set and of one coordinate.
   localparam int MAX_POINTS_DEF  = 32;
   localparam int COORD_BITS_DEF  = 16;
   // At most this many hull vertices are sent out per set.
   localparam int MAX_RESULTS     = 32;

   // Operation of the shared compare unit.
   typedef enum logic {
      CMP_TURN,
      CMP_DIST
   } cmp_mode_type;

   // Three-way result of the compare unit.
   typedef struct packed {
      logic lt;
      logic eq;
      logic gt;
   } cmp_res_type;

   // Control bits that travel with a queued item.
   typedef struct packed {
      logic store;
      logic last;
   } q_ctl_type;

   // Sequencer states of the back end.
   typedef enum logic [4:0] {
      ST_LOAD,
      ST_START,
      ST_SM0,
      ST_SM1,
      ST_PV_INIT,
      ST_PV_SCAN,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_SORT_T,
      ST_SORT_V,
      ST_SORT_W1,
      ST_SORT_W2,
      ST_SORT_DEC,
      ST_SORT_PUT,
      ST_COL_START,
      ST_COL_A,
      ST_COL_B,
      ST_COL_W,
      ST_STK0,
      ST_STK1,
      ST_STK2,
      ST_HULL_NEXT,
      ST_HULL_K,
      ST_HULL_S,
      ST_HULL_W,
      ST_HULL_PUSH,
      ST_OUT_SET,
      ST_OUT_RD,
      ST_OUT_LD
   } back_state_type;

endpackage

// ===== hw/rtl/convex_hull_scan_top.sv =====
// ----------------------------------------------------------------------------
// Convex hull scan top level
// Graham scan convex hull of a set of signed integer points.
//
//   Channel   Handshake              Payload
//   req       req_valid/req_ready    req_point_x, req_point_y, req_final_point
//   rsp       rsp_valid/rsp_ready    rsp_vertex_x, rsp_vertex_y,
//                                    rsp_final_vertex, rsp_overflow
//
// Points are stored at one per cycle through a two-entry queue. On the final
// point the back end works on the stored set: pivot search and swap, an
// insertion sort about the pivot (with a distance compare when two points
// lie on one ray), a pass over the points on the first ray, and a stack
// scan with one turn test per stack step. The registered point memory and
// the three-stage compare unit pace these steps. The vertices are then sent
// out in turn. Reset is synchronous and clears the control state only.
// While a set is processed the queue fills and req_ready drops; rsp_ready
// low holds the sequencer.
// ----------------------------------------------------------------------------
module convex_hull_scan_top
   import chs_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic                         req_final_point,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_vertex_x,
   output logic signed [COORD_BITS-1:0] rsp_vertex_y,
   output logic                         rsp_final_vertex,
   output logic                         rsp_overflow
);

   logic                    q_valid;
   q_ctl_type               q_ctl;
   logic [2*COORD_BITS-1:0] q_data;
   logic                    q_pop;

   chs_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_final_point (req_final_point),
      .q_valid         (q_valid),
      .q_ctl           (q_ctl),
      .q_data          (q_data),
      .q_pop           (q_pop)
   );

   chs_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_ctl            (q_ctl),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vertex_x     (rsp_vertex_x),
      .rsp_vertex_y     (rsp_vertex_y),
      .rsp_final_vertex (rsp_final_vertex),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

// ===== hw/rtl/chs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chs_ram
   import chs_pkg::*;
#(
   parameter int WIDTH = 2 * COORD_BITS_DEF,
   parameter int DEPTH = MAX_POINTS_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== hw/rtl/chs_front.sv =====
// ----------------------------------------------------------------------------
// Convex hull scan front end
// Accepts points, decides whether each one is stored or dropped, and
// places it in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module chs_front
   import chs_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic                         req_final_point,
   output logic                         q_valid,
   output q_ctl_type                    q_ctl,
   output logic [2*COORD_BITS-1:0]      q_data,
   input  logic                         q_pop
);

   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int PW = 2 * COORD_BITS;

   logic [CW-1:0]  count_ff, count_in;
   logic [PW-1:0]  qd_ff [2];
   q_ctl_type      qc_ff [2];
   logic           wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]     fill_ff, fill_in;
   logic           push;
   q_ctl_type      ctl_new;

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_data    = qd_ff[rp_ff];
   assign q_ctl     = qc_ff[rp_ff];

   // Classify the incoming item and track the size of the current set.
   always_comb begin
      ctl_new.store = (count_ff < CW'(MAX_POINTS));
      ctl_new.last  = req_final_point;
      count_in      = count_ff;
      if (push) begin
         if (req_final_point) begin
            count_in = '0;
         end else if (ctl_new.store) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   // Queue pointers and fill level.
   always_comb begin
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      fill_in = fill_ff;
      if (push) begin
         wp_in = ~wp_ff;
      end
      if (q_pop) begin
         rp_in = ~rp_ff;
      end
      if (push && !q_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
         fill_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         fill_ff  <= fill_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         qd_ff[wp_ff] <= {req_point_y, req_point_x};
         qc_ff[wp_ff] <= ctl_new;
      end
   end

endmodule

// ===== hw/rtl/chs_cmp.sv =====
// ----------------------------------------------------------------------------
// Convex hull scan compare unit
// Three-stage unit that compares two cross-product terms about a point,
// or the squared distances of two points from it.
// ----------------------------------------------------------------------------
module chs_cmp
   import chs_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  cmp_mode_type                 mode,
   input  logic signed [COORD_BITS-1:0] o_x,
   input  logic signed [COORD_BITS-1:0] o_y,
   input  logic signed [COORD_BITS-1:0] p_x,
   input  logic signed [COORD_BITS-1:0] p_y,
   input  logic signed [COORD_BITS-1:0] q_x,
   input  logic signed [COORD_BITS-1:0] q_y,
   output logic                         done,
   output cmp_res_type                  res
);

   localparam int DW = COORD_BITS + 1;
   localparam int MW = 2 * DW;
   localparam int SW = MW + 1;

   logic signed [DW-1:0] dpx_ff, dpy_ff, dqx_ff, dqy_ff;
   cmp_mode_type         mode_ff;
   logic                 v0_ff, v1_ff, v2_ff;
   logic signed [DW-1:0] a1, b1, a2, b2, a3, b3, a4, b4;
   logic signed [MW-1:0] pr1_ff, pr2_ff, pr3_ff, pr4_ff;
   logic signed [MW-1:0] pr1_in, pr2_in, pr3_in, pr4_in;
   logic signed [SW-1:0] sa, sb;
   cmp_res_type          res_ff;

   // Stage one: coordinate differences.
   always_ff @(posedge clock) begin
      dpx_ff  <= DW'(p_x) - DW'(o_x);
      dpy_ff  <= DW'(p_y) - DW'(o_y);
      dqx_ff  <= DW'(q_x) - DW'(o_x);
      dqy_ff  <= DW'(q_y) - DW'(o_y);
      mode_ff <= mode;
   end

   // Stage two: operand selection and the four products.
   always_comb begin
      if (mode_ff == CMP_TURN) begin
         a1 = dpy_ff;
         b1 = dqx_ff;
         a2 = '0;
         b2 = '0;
         a3 = dqy_ff;
         b3 = dpx_ff;
         a4 = '0;
         b4 = '0;
      end else begin
         a1 = dpx_ff;
         b1 = dpx_ff;
         a2 = dpy_ff;
         b2 = dpy_ff;
         a3 = dqx_ff;
         b3 = dqx_ff;
         a4 = dqy_ff;
         b4 = dqy_ff;
      end
      pr1_in = MW'(a1) * MW'(b1);
      pr2_in = MW'(a2) * MW'(b2);
      pr3_in = MW'(a3) * MW'(b3);
      pr4_in = MW'(a4) * MW'(b4);
   end

   always_ff @(posedge clock) begin
      pr1_ff <= pr1_in;
      pr2_ff <= pr2_in;
      pr3_ff <= pr3_in;
      pr4_ff <= pr4_in;
   end

   // Stage three: add the pairs and compare.
   assign sa = SW'(pr1_ff) + SW'(pr2_ff);
   assign sb = SW'(pr3_ff) + SW'(pr4_ff);

   always_ff @(posedge clock) begin
      res_ff.lt <= (sa < sb);
      res_ff.eq <= (sa == sb);
      res_ff.gt <= (sa > sb);
   end

   // Valid bits that follow the operation through the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= go;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   assign done = v2_ff;
   assign res  = res_ff;

endmodule

// ===== hw/rtl/chs_back.sv =====
// ----------------------------------------------------------------------------
// Convex hull scan back end
// Stores queued points, then runs the pivot search, insertion sort and
// stack scan over the point memory and sends out the hull vertices.
// ----------------------------------------------------------------------------
module chs_back
   import chs_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  q_ctl_type                    q_ctl,
   input  logic [2*COORD_BITS-1:0]      q_data,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_vertex_x,
   output logic signed [COORD_BITS-1:0] rsp_vertex_y,
   output logic                         rsp_final_vertex,
   output logic                         rsp_overflow
);

   localparam int C  = COORD_BITS;
   localparam int PW = 2 * C;
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   back_state_type state_ff, state_in;
   logic [CW-1:0]  n_ff, n_in, i_ff, i_in, j_ff, j_in, l_ff, l_in, k_ff, k_in;
   logic [CW-1:0]  m_ff, m_in, depth_ff, depth_in, cnt_ff, cnt_in, idx_ff, idx_in;
   logic           dropped_ff, dropped_in, before_ff, before_in;
   logic [AW-1:0]  left_ff, left_in;
   logic [PW-1:0]  lp_ff, lp_in, piv_ff, piv_in, t_ff, t_in, v_ff, v_in;
   logic [PW-1:0]  prv_ff, prv_in, cur_ff, cur_in, top_ff, top_in;
   logic [PW-1:0]  s1_ff, s1_in, pk_ff, pk_in;
   logic           rsp_valid_ff, rsp_valid_in, rfin_ff, rfin_in, rovf_ff, rovf_in;
   logic [C-1:0]   rx_ff, rx_in, ry_ff, ry_in;

   logic           p_we, s_we;
   logic [AW-1:0]  p_wa, p_ra, s_wa, s_ra;
   logic [PW-1:0]  p_wd, p_rd, s_wd, s_rd;
   logic           cmp_go, cmp_done;
   cmp_mode_type   cmp_mode;
   logic [PW-1:0]  cmp_o, cmp_p, cmp_q;
   cmp_res_type    cmp_res;
   logic           rd_less;

   chs_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_point_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (p_wa),
      .wdata (p_wd),
      .raddr (p_ra),
      .rdata (p_rd)
   );

   chs_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_stack_ram (
      .clock (clock),
      .we    (s_we),
      .waddr (s_wa),
      .wdata (s_wd),
      .raddr (s_ra),
      .rdata (s_rd)
   );

   chs_cmp #(.COORD_BITS(C)) u_cmp (
      .clock (clock),
      .reset (reset),
      .go    (cmp_go),
      .mode  (cmp_mode),
      .o_x   (cmp_o[C-1:0]),
      .o_y   (cmp_o[PW-1:C]),
      .p_x   (cmp_p[C-1:0]),
      .p_y   (cmp_p[PW-1:C]),
      .q_x   (cmp_q[C-1:0]),
      .q_y   (cmp_q[PW-1:C]),
      .done  (cmp_done),
      .res   (cmp_res)
   );

   // Lower x, then lower y, wins the pivot search.
   assign rd_less = ($signed(p_rd[C-1:0]) < $signed(lp_ff[C-1:0])) ||
                    ((p_rd[C-1:0] == lp_ff[C-1:0]) &&
                     ($signed(p_rd[PW-1:C]) < $signed(lp_ff[PW-1:C])));

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_x     = rx_ff;
   assign rsp_vertex_y     = ry_ff;
   assign rsp_final_vertex = rfin_ff;
   assign rsp_overflow     = rovf_ff;

   // Sequencer: next state, memory accesses and compare requests.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      l_in         = l_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      depth_in     = depth_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      dropped_in   = dropped_ff;
      before_in    = before_ff;
      left_in      = left_ff;
      lp_in        = lp_ff;
      piv_in       = piv_ff;
      t_in         = t_ff;
      v_in         = v_ff;
      prv_in       = prv_ff;
      cur_in       = cur_ff;
      top_in       = top_ff;
      s1_in        = s1_ff;
      pk_in        = pk_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rfin_in      = rfin_ff;
      rovf_in      = rovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      p_we         = 1'b0;
      p_wa         = '0;
      p_wd         = '0;
      p_ra         = '0;
      s_we         = 1'b0;
      s_wa         = '0;
      s_wd         = '0;
      s_ra         = '0;
      q_pop        = 1'b0;
      cmp_go       = 1'b0;
      cmp_mode     = CMP_TURN;
      cmp_o        = '0;
      cmp_p        = '0;
      cmp_q        = '0;

      unique case (state_ff)
         // Collect the points of one set.
         ST_LOAD: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_ctl.store) begin
                  p_we = 1'b1;
                  p_wa = n_ff[AW-1:0];
                  p_wd = q_data;
                  n_in = n_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (q_ctl.last) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            p_ra = '0;
            if (n_ff == '0) begin
               depth_in = '0;
               state_in = ST_OUT_SET;
            end else if (n_ff < CW'(3)) begin
               state_in = ST_SM0;
            end else begin
               state_in = ST_PV_INIT;
            end
         end
         // One or two points go out as given; a second point equal to the first is dropped.
         ST_SM0: begin
            lp_in    = p_rd;
            s_we     = 1'b1;
            s_wa     = '0;
            s_wd     = p_rd;
            depth_in = CW'(1);
            p_ra     = AW'(1);
            state_in = ST_SM1;
         end
         ST_SM1: begin
            if ((n_ff == CW'(2)) && (p_rd != lp_ff)) begin
               s_we     = 1'b1;
               s_wa     = AW'(1);
               s_wd     = p_rd;
               depth_in = CW'(2);
            end
            state_in = ST_OUT_SET;
         end
         // Pivot search, one point a cycle.
         ST_PV_INIT: begin
            lp_in    = p_rd;
            left_in  = '0;
            i_in     = CW'(1);
            p_ra     = AW'(1);
            state_in = ST_PV_SCAN;
         end
         ST_PV_SCAN: begin
            if (rd_less) begin
               lp_in   = p_rd;
               left_in = i_ff[AW-1:0];
            end
            if (i_ff == n_ff - CW'(1)) begin
               p_ra     = '0;
               state_in = ST_SWAP_A;
            end else begin
               i_in     = i_ff + CW'(1);
               p_ra     = AW'(i_ff + CW'(1));
               state_in = ST_PV_SCAN;
            end
         end
         // Move the pivot to the front.
         ST_SWAP_A: begin
            p_we     = 1'b1;
            p_wa     = left_ff;
            p_wd     = p_rd;
            piv_in   = lp_ff;
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            p_we     = 1'b1;
            p_wa     = '0;
            p_wd     = piv_ff;
            i_in     = CW'(2);
            j_in     = CW'(2);
            p_ra     = AW'(2);
            state_in = ST_SORT_T;
         end
         // Insertion sort about the pivot.
         ST_SORT_T: begin
            t_in     = p_rd;
            p_ra     = AW'(j_ff - CW'(1));
            state_in = ST_SORT_V;
         end
         ST_SORT_V: begin
            v_in = p_rd;
            if (p_rd == piv_ff) begin
               before_in = 1'b0;
               state_in  = ST_SORT_DEC;
            end else if (t_ff == piv_ff) begin
               before_in = 1'b1;
               state_in  = ST_SORT_DEC;
            end else begin
               cmp_go   = 1'b1;
               cmp_mode = CMP_TURN;
               cmp_o    = piv_ff;
               cmp_p    = t_ff;
               cmp_q    = p_rd;
               state_in = ST_SORT_W1;
            end
         end
         ST_SORT_W1: begin
            if (cmp_done) begin
               if (cmp_res.eq) begin
                  cmp_go   = 1'b1;
                  cmp_mode = CMP_DIST;
                  cmp_o    = piv_ff;
                  cmp_p    = t_ff;
                  cmp_q    = v_ff;
                  state_in = ST_SORT_W2;
               end else begin
                  before_in = cmp_res.gt;
                  state_in  = ST_SORT_DEC;
               end
            end
         end
         ST_SORT_W2: begin
            if (cmp_done) begin
               before_in = cmp_res.lt;
               state_in  = ST_SORT_DEC;
            end
         end
         ST_SORT_DEC: begin
            if (before_ff) begin
               p_we = 1'b1;
               p_wa = j_ff[AW-1:0];
               p_wd = v_ff;
               j_in = j_ff - CW'(1);
               if (j_ff > CW'(2)) begin
                  p_ra     = AW'(j_ff - CW'(2));
                  state_in = ST_SORT_V;
               end else begin
                  state_in = ST_SORT_PUT;
               end
            end else begin
               state_in = ST_SORT_PUT;
            end
         end
         ST_SORT_PUT: begin
            p_we = 1'b1;
            p_wa = j_ff[AW-1:0];
            p_wd = t_ff;
            if (i_ff + CW'(1) < n_ff) begin
               i_in     = i_ff + CW'(1);
               j_in     = i_ff + CW'(1);
               p_ra     = AW'(i_ff + CW'(1));
               state_in = ST_SORT_T;
            end else begin
               state_in = ST_COL_START;
            end
         end
         // Skip the leading points that lie on the first ray.
         ST_COL_START: begin
            p_ra     = AW'(1);
            state_in = ST_COL_A;
         end
         ST_COL_A: begin
            prv_in   = p_rd;
            l_in     = CW'(2);
            p_ra     = AW'(2);
            state_in = ST_COL_B;
         end
         ST_COL_B: begin
            cur_in   = p_rd;
            cmp_go   = 1'b1;
            cmp_mode = CMP_TURN;
            cmp_o    = piv_ff;
            cmp_p    = p_rd;
            cmp_q    = prv_ff;
            state_in = ST_COL_W;
         end
         ST_COL_W: begin
            if (cmp_done) begin
               if (cmp_res.eq) begin
                  prv_in = cur_ff;
                  l_in   = l_ff + CW'(1);
                  if (l_ff + CW'(1) < n_ff) begin
                     p_ra     = AW'(l_ff + CW'(1));
                     state_in = ST_COL_B;
                  end else begin
                     state_in = ST_STK0;
                  end
               end else begin
                  state_in = ST_STK0;
               end
            end
         end
         // Seed the stack.
         ST_STK0: begin
            s_we     = 1'b1;
            s_wa     = '0;
            s_wd     = piv_ff;
            state_in = ST_STK1;
         end
         ST_STK1: begin
            s_we     = 1'b1;
            s_wa     = AW'(1);
            s_wd     = prv_ff;
            depth_in = CW'(2);
            top_in   = prv_ff;
            if (l_ff < n_ff) begin
               state_in = ST_STK2;
            end else begin
               state_in = ST_OUT_SET;
            end
         end
         ST_STK2: begin
            s_we     = 1'b1;
            s_wa     = AW'(2);
            s_wd     = cur_ff;
            depth_in = CW'(3);
            top_in   = cur_ff;
            k_in     = l_ff + CW'(1);
            state_in = ST_HULL_NEXT;
         end
         // Stack scan over the remaining sorted points.
         ST_HULL_NEXT: begin
            if (k_ff < n_ff) begin
               p_ra     = k_ff[AW-1:0];
               m_in     = depth_ff - CW'(1);
               state_in = ST_HULL_K;
            end else begin
               state_in = ST_OUT_SET;
            end
         end
         ST_HULL_K: begin
            pk_in = p_rd;
            if (m_ff >= CW'(2)) begin
               s_ra     = AW'(m_ff - CW'(1));
               state_in = ST_HULL_S;
            end else begin
               state_in = ST_HULL_PUSH;
            end
         end
         ST_HULL_S: begin
            s1_in    = s_rd;
            cmp_go   = 1'b1;
            cmp_mode = CMP_TURN;
            cmp_o    = s_rd;
            cmp_p    = pk_ff;
            cmp_q    = top_ff;
            state_in = ST_HULL_W;
         end
         ST_HULL_W: begin
            if (cmp_done) begin
               if (!cmp_res.lt) begin
                  m_in   = m_ff - CW'(1);
                  top_in = s1_ff;
                  if (m_ff >= CW'(3)) begin
                     s_ra     = AW'(m_ff - CW'(2));
                     state_in = ST_HULL_S;
                  end else begin
                     state_in = ST_HULL_PUSH;
                  end
               end else begin
                  state_in = ST_HULL_PUSH;
               end
            end
         end
         ST_HULL_PUSH: begin
            if (m_ff + CW'(1) < CW'(MAX_POINTS)) begin
               s_we     = 1'b1;
               s_wa     = AW'(m_ff + CW'(1));
               s_wd     = pk_ff;
               top_in   = pk_ff;
               depth_in = m_ff + CW'(2);
            end else begin
               depth_in = m_ff + CW'(1);
            end
            k_in     = k_ff + CW'(1);
            state_in = ST_HULL_NEXT;
         end
         // Send the stack bottom to top.
         ST_OUT_SET: begin
            if (int'(depth_ff) > MAX_RESULTS) begin
               cnt_in = CW'(MAX_RESULTS);
            end else begin
               cnt_in = depth_ff;
            end
            idx_in   = '0;
            state_in = ST_OUT_RD;
         end
         ST_OUT_RD: begin
            if (idx_ff == cnt_ff) begin
               n_in       = '0;
               dropped_in = 1'b0;
               state_in   = ST_LOAD;
            end else if (!rsp_valid_ff || rsp_ready) begin
               s_ra     = idx_ff[AW-1:0];
               state_in = ST_OUT_LD;
            end
         end
         ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rx_in        = s_rd[C-1:0];
            ry_in        = s_rd[PW-1:C];
            rfin_in      = (idx_ff + CW'(1) == cnt_ff);
            rovf_in      = dropped_ff;
            idx_in       = idx_ff + CW'(1);
            state_in     = ST_OUT_RD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         n_ff         <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      l_ff      <= l_in;
      k_ff      <= k_in;
      m_ff      <= m_in;
      depth_ff  <= depth_in;
      cnt_ff    <= cnt_in;
      idx_ff    <= idx_in;
      before_ff <= before_in;
      left_ff   <= left_in;
      lp_ff     <= lp_in;
      piv_ff    <= piv_in;
      t_ff      <= t_in;
      v_ff      <= v_in;
      prv_ff    <= prv_in;
      cur_ff    <= cur_in;
      top_ff    <= top_in;
      s1_ff     <= s1_in;
      pk_ff     <= pk_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      rfin_ff   <= rfin_in;
      rovf_ff   <= rovf_in;
   end

endmodule
